>>> rtl/stpe_pkg.sv
// ----------------------------------------------------------------------------
// stpe_pkg
// Shared types, constants and helpers of the stereo true-peak estimator:
// Catmull-Rom phase weights, peak format, stage control and register map.
// ----------------------------------------------------------------------------
package stpe_pkg;

  // Peak value format, in units of 1/128 sample LSB.
  localparam int unsigned PEAK_BITS = 23;
  localparam logic [PEAK_BITS-1:0] PEAK_MAX = {PEAK_BITS{1'b1}};

  typedef logic [PEAK_BITS-1:0] peak_t;

  // Interpolation geometry: four history taps, five phases t = 0 .. 1.
  localparam int unsigned NUM_TAPS   = 4;
  localparam int unsigned NUM_PHASES = 5;

  // Signed weights scaled by 128; each phase row sums to 128.
  localparam int unsigned WEIGHT_BITS = 9;
  typedef logic signed [WEIGHT_BITS-1:0] weight_t;

  localparam weight_t PHASE_WEIGHTS [NUM_PHASES][NUM_TAPS] = '{
    '{ 9'sd0,   9'sd128, 9'sd0,   9'sd0  },
    '{-9'sd9,   9'sd111, 9'sd29, -9'sd3  },
    '{-9'sd8,   9'sd72,  9'sd72, -9'sd8  },
    '{-9'sd3,   9'sd29,  9'sd111, -9'sd9 },
    '{ 9'sd0,   9'sd0,   9'sd128, 9'sd0  }
  };

  // Control carried by the history stage to the result stage.
  typedef struct packed {
    logic valid;
    logic restart;
    logic full;
  } stage_ctl_t;

  // Register map: one 32-bit register per word.
  localparam int unsigned ADDR_BITS = 3;
  localparam int unsigned DATA_BITS = 32;
  localparam logic [ADDR_BITS-3:0] REG_MONO_MODE = '0;

  // History fill level at which interpolation starts.
  localparam logic [2:0] FILL_FULL = 3'd4;

  // Larger of two unsigned peak values.
  function automatic peak_t peak_max(peak_t a, peak_t b);
    peak_max = (a > b) ? a : b;
  endfunction

endpackage

>>> rtl/stpe_history.sv
// ----------------------------------------------------------------------------
// stpe_history
// Input stage: four-deep sample history per channel, fill count and the
// control register that hands each accepted frame to the result stage.
// ----------------------------------------------------------------------------
module stpe_history
  import stpe_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          advance,
  input  logic                          mono_mode,
  input  logic                          restart,
  input  logic signed [SAMPLE_BITS-1:0] left_sample,
  input  logic signed [SAMPLE_BITS-1:0] right_sample,
  output logic signed [SAMPLE_BITS-1:0] left_history  [NUM_TAPS],
  output logic signed [SAMPLE_BITS-1:0] right_history [NUM_TAPS],
  output stage_ctl_t                    ctl
);

  logic [2:0] fill_count;
  logic [2:0] fill_base;
  logic [2:0] fill_count_next;
  logic signed [SAMPLE_BITS-1:0] right_in;

  // A restart frame starts from an empty history.
  assign fill_base       = restart ? 3'd0 : fill_count;
  assign fill_count_next = (fill_base < FILL_FULL) ? fill_base + 3'd1 : fill_base;
  assign right_in        = mono_mode ? left_sample : right_sample;

  // History shift and control; the history holds unless a frame is taken, and valid clears on advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= '0;
      ctl           <= '0;
      left_history  <= '{default: '0};
      right_history <= '{default: '0};
    end else begin
      if (accept) begin
        for (int i = 0; i < NUM_TAPS - 1; i++) begin
          left_history[i]  <= restart ? '0 : left_history[i+1];
          right_history[i] <= restart ? '0 : right_history[i+1];
        end
        left_history[NUM_TAPS-1]  <= left_sample;
        right_history[NUM_TAPS-1] <= right_in;
        fill_count  <= fill_count_next;
        ctl.valid   <= 1'b1;
        ctl.restart <= restart;
        ctl.full    <= (fill_count_next == FILL_FULL);
      end else if (advance) begin
        ctl.valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/stpe_interp.sv
// ----------------------------------------------------------------------------
// stpe_interp
// One channel: evaluates the Catmull-Rom curve over the middle interval at
// five phases, takes magnitudes, saturates, and returns the largest.
// ----------------------------------------------------------------------------
module stpe_interp
  import stpe_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic signed [SAMPLE_BITS-1:0] history [NUM_TAPS],
  output peak_t                         chan_max
);

  // Weighted sums stay below 2^(SAMPLE_BITS+11) in magnitude.
  localparam int unsigned VW = SAMPLE_BITS + 12;

  logic signed [VW-1:0] tap   [NUM_TAPS];
  logic signed [VW-1:0] value [NUM_PHASES];
  logic        [VW-1:0] mag   [NUM_PHASES];
  peak_t                sat   [NUM_PHASES];
  peak_t                max01, max23, max0123;

  // Sign-extend the taps to the working width.
  always_comb begin
    for (int i = 0; i < NUM_TAPS; i++) begin
      tap[i] = {{(VW-SAMPLE_BITS){history[i][SAMPLE_BITS-1]}}, history[i]};
    end
  end

  // Four-tap constant-weight sum per phase, then magnitude and saturation.
  always_comb begin
    for (int k = 0; k < NUM_PHASES; k++) begin
      value[k] = '0;
      for (int i = 0; i < NUM_TAPS; i++) begin
        value[k] = value[k] + tap[i] *
          {{(VW-WEIGHT_BITS){PHASE_WEIGHTS[k][i][WEIGHT_BITS-1]}}, PHASE_WEIGHTS[k][i]};
      end
      mag[k] = value[k][VW-1] ? VW'(-value[k]) : VW'(value[k]);
      sat[k] = (mag[k] > VW'(PEAK_MAX)) ? PEAK_MAX : mag[k][PEAK_BITS-1:0];
    end
  end

  // Balanced maximum over the five phases.
  assign max01    = peak_max(sat[0], sat[1]);
  assign max23    = peak_max(sat[2], sat[3]);
  assign max0123  = peak_max(max01, max23);
  assign chan_max = peak_max(max0123, sat[4]);

endmodule

>>> rtl/stereo_true_peak_estimator_core.sv
// ----------------------------------------------------------------------------
// stereo_true_peak_estimator_core
// 4x oversampled true-peak estimator for stereo PCM frames, with a mono
// mode register on an APB-style port.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat contents
//  s_axis    in         tdata: left_sample, right_sample; tuser: restart
//  m_axis    out        tdata: true_peak (zero padded); tuser: history_full
//  apb       in/out     register 0 at byte 0: mono_mode (bit 0)
//
// One frame is accepted every cycle unless an m_axis stall leaves both stages
// full. An accepted frame loads the history register; the peak register then
// loads through the interpolation and maximum logic and offers the result beat.
// Reset clears history, fill count, peak, mono_mode and all valid flags.
// A stall on m_axis holds both stages; s_tready drops only when both hold a
// frame, and frames are never dropped or repeated.
module stereo_true_peak_estimator_core
  import stpe_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // tdata: left_sample, right_sample (from bit 0), zero padded to bytes
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
  // tuser: restart
  input  logic                  s_tuser,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // tdata: true_peak, zero padded to bytes
  output logic [((PEAK_BITS+7)/8)*8-1:0] m_tdata,
  // tuser: history_full
  output logic                  m_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_BITS-1:0]  paddr,
  input  logic [DATA_BITS-1:0]  pwdata,
  output logic [DATA_BITS-1:0]  prdata,
  output logic                  pready
);

  localparam int unsigned OUT_BITS = ((PEAK_BITS + 7) / 8) * 8;

  logic       mono_mode;
  logic       accept;
  logic       advance;
  stage_ctl_t ctl;
  peak_t      peak;
  peak_t      peak_base;
  peak_t      left_max, right_max, frame_max;
  logic       history_full;

  logic signed [SAMPLE_BITS-1:0] left_history  [NUM_TAPS];
  logic signed [SAMPLE_BITS-1:0] right_history [NUM_TAPS];

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_BITS-1:2] == REG_MONO_MODE) ?
                  {{(DATA_BITS-1){1'b0}}, mono_mode} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mono_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[ADDR_BITS-1:2] == REG_MONO_MODE) begin
      mono_mode <= pwdata[0];
    end
  end

  // Handshake: the result register empties or is taken, the pipeline moves.
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !ctl.valid || advance;
  assign accept   = s_tvalid && s_tready;

  // History stage.
  stpe_history #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_history (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .advance       (advance),
    .mono_mode     (mono_mode),
    .restart       (s_tuser),
    .left_sample   (s_tdata[SAMPLE_BITS-1:0]),
    .right_sample  (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .left_history  (left_history),
    .right_history (right_history),
    .ctl           (ctl)
  );

  // Interpolation of each channel's middle interval.
  stpe_interp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_interp_left (
    .history  (left_history),
    .chan_max (left_max)
  );

  stpe_interp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_interp_right (
    .history  (right_history),
    .chan_max (right_max)
  );

  // Running peak; a restart frame begins from zero.
  assign peak_base = ctl.restart ? '0 : peak;
  assign frame_max = peak_max(left_max, right_max);

  always_ff @(posedge clk) begin
    if (rst) begin
      peak         <= '0;
      history_full <= 1'b0;
      m_tvalid     <= 1'b0;
    end else if (advance) begin
      m_tvalid <= ctl.valid;
      if (ctl.valid) begin
        peak         <= ctl.full ? peak_max(peak_base, frame_max) : peak_base;
        history_full <= ctl.full;
      end
    end
  end

  assign m_tdata = {{(OUT_BITS-PEAK_BITS){1'b0}}, peak};
  assign m_tuser = history_full;

  // The peak only grows between restarts.
  a_peak_monotonic: assert property (@(posedge clk) disable iff (rst)
    (advance && ctl.valid && !ctl.restart) |=> peak >= $past(peak))
    else $error("peak decreased without restart");

  // A held frame keeps the newest history entries untouched.
  a_history_held: assert property (@(posedge clk) disable iff (rst)
    (ctl.valid && !advance) |=>
      $stable(left_history[NUM_TAPS-1]) && $stable(right_history[NUM_TAPS-1]))
    else $error("history moved during a stall");

  // In mono mode both channels take the same newest sample.
  a_mono_copy: assert property (@(posedge clk) disable iff (rst)
    (accept && mono_mode) |=> left_history[NUM_TAPS-1] == right_history[NUM_TAPS-1])
    else $error("mono mode right history differs from left");

endmodule

>>> verif/stereo_true_peak_estimator_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_true_peak_estimator_core_test
// Self-checking bench for the stereo true-peak estimator. Stereo frames go
// into the stream input, and each frame's peak beat is checked against a
// bit-exact Catmull-Rom predictor held in the bench. Both stream sides idle
// at random, the receiver holds off once for a long stretch, and mono_mode
// is switched over the APB port between phases.
// ----------------------------------------------------------------------------
module stereo_true_peak_estimator_core_test
  import stpe_pkg::*;
();

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned IN_BYTES_BITS = ((2*SAMPLE_BITS+7)/8)*8;
  localparam int unsigned OUT_BYTES_BITS = ((PEAK_BITS+7)/8)*8;
  localparam logic [ADDR_BITS-1:0] MONO_ADDR = {REG_MONO_MODE, 2'b00};
  localparam logic [ADDR_BITS-1:0] UNUSED_ADDR = 3'd4;
  localparam int unsigned PIPE_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned IDLE_PERCENT = 18;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct {
    peak_t peak;
    logic  full;
  } frame_result_t;

  logic                         clk;
  logic                         rst;
  logic [IN_BYTES_BITS-1:0]     s_tdata;
  logic                         s_tuser;
  logic                         s_tvalid;
  logic                         s_tready;
  logic [OUT_BYTES_BITS-1:0]    m_tdata;
  logic                         m_tuser;
  logic                         m_tvalid;
  logic                         m_tready;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [ADDR_BITS-1:0]         paddr;
  logic [DATA_BITS-1:0]         pwdata;
  logic [DATA_BITS-1:0]         prdata;
  logic                         pready;

  // Predictor state: channel histories, fill level, held peak and register.
  sample_t       left_taps [NUM_TAPS];
  sample_t       right_taps [NUM_TAPS];
  logic [2:0]    frames_held;
  peak_t         peak_now;
  logic          mono_shadow;
  frame_result_t pending_peaks [$];

  int unsigned   error_count;
  bit            steady;
  bit            hold_request;
  bit            beat_moved;

  stereo_true_peak_estimator_core #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Largest absolute value over the five phases of one channel's middle
  // interval, merged with the peak held so far.
  function automatic peak_t interval_peak(sample_t h [NUM_TAPS], peak_t held);
    longint d1, d2, d3, v, a;
    peak_t  best;
    best = held;
    d1 = longint'(h[2]) - longint'(h[0]);
    d2 = 2*longint'(h[0]) - 5*longint'(h[1]) + 4*longint'(h[2]) - longint'(h[3]);
    d3 = -longint'(h[0]) + 3*longint'(h[1]) - 3*longint'(h[2]) + longint'(h[3]);
    for (int k = 0; k <= 4; k++) begin
      v = 128*longint'(h[1]) + 16*k*d1 + 4*k*k*d2 + k*k*k*d3;
      a = (v < 0) ? -v : v;
      if (a > longint'(PEAK_MAX)) begin
        a = longint'(PEAK_MAX);
      end
      if (a > longint'(best)) begin
        best = peak_t'(a);
      end
    end
    return best;
  endfunction

  // Advance the predictor by one accepted frame and queue its result.
  task automatic predict_frame(input logic restart, input sample_t left, input sample_t right);
    frame_result_t r;
    sample_t       rs;
    if (restart) begin
      for (int i = 0; i < NUM_TAPS; i++) begin
        left_taps[i] = '0;
        right_taps[i] = '0;
      end
      frames_held = '0;
      peak_now = '0;
    end
    rs = mono_shadow ? left : right;
    for (int i = 0; i < NUM_TAPS-1; i++) begin
      left_taps[i] = left_taps[i+1];
      right_taps[i] = right_taps[i+1];
    end
    left_taps[NUM_TAPS-1] = left;
    right_taps[NUM_TAPS-1] = rs;
    if (frames_held < FILL_FULL) begin
      frames_held = frames_held + 3'd1;
    end
    if (frames_held == FILL_FULL) begin
      peak_now = interval_peak(left_taps, peak_now);
      peak_now = interval_peak(right_taps, peak_now);
    end
    r.peak = peak_now;
    r.full = (frames_held == FILL_FULL);
    pending_peaks.push_back(r);
  endtask

  // Offer one frame, after a random idle gap, and wait for its acceptance.
  task automatic send_frame(input logic restart, input sample_t left, input sample_t right);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= restart;
    s_tdata <= {right, left};
    do @(posedge clk); while (!s_tready);
    predict_frame(restart, left, right);
  endtask

  // Stop offering frames and let every expected beat come out.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_peaks.size() != 0) @(posedge clk);
    repeat (PIPE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [ADDR_BITS-1:0] addr, input logic [DATA_BITS-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == MONO_ADDR) begin
      mono_shadow = data[0];
    end
  endtask

  // Read mono_mode back and compare it with the predictor's copy.
  task automatic check_mono_readback();
    logic [DATA_BITS-1:0] want;
    want = {{(DATA_BITS-1){1'b0}}, mono_shadow};
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= MONO_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $display("%0t mono_mode readback: expected %h, actual %h", $time, want, prdata);
      error_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(5))
      0, 1: return sample_t'($urandom);
      2: return sample_t'($urandom_range(600)) - sample_t'(300);
      3: return $urandom_range(1) ? sample_t'(16'h7FFF) : sample_t'(16'h8000);
      4: return sample_t'($urandom_range(4000)) - sample_t'(2000);
      default: return $urandom_range(1) ? sample_t'(16'h7000) : sample_t'(16'h9000);
    endcase
  endfunction

  // Start of a track: history fills over four frames, then interpolation runs.
  task automatic test_fill_sequence();
    send_frame(1'b1, 16'sd0, 16'sd0);
    send_frame(1'b0, 16'sd100, -16'sd100);
    send_frame(1'b0, 16'sd200, -16'sd200);
    send_frame(1'b0, -16'sd1, 16'sd1);
    send_frame(1'b0, 16'sd300, 16'sd5);
  endtask

  // Full-scale swings that overshoot between samples.
  task automatic test_sample_extremes();
    send_frame(1'b1, 16'sh8000, 16'sh7FFF);
    send_frame(1'b0, 16'sh7FFF, 16'sh8000);
    send_frame(1'b0, 16'sh7FFF, 16'sh8000);
    send_frame(1'b0, 16'sh8000, 16'sh7FFF);
    send_frame(1'b0, 16'sh8000, 16'sh7FFF);
    send_frame(1'b0, 16'sh7FFF, 16'sh8000);
  endtask

  // A restart before the history has filled begins a new track.
  task automatic test_restart();
    send_frame(1'b1, 16'sd50, 16'sd60);
    send_frame(1'b0, 16'sd70, 16'sd80);
    send_frame(1'b1, 16'sh5555, 16'shAAAA);
    send_frame(1'b1, 16'sd1, 16'sd2);
  endtask

  // Mono mode ignores the right sample; a write to an unused address is lost.
  task automatic test_mono_mode();
    drain_results();
    apb_write(MONO_ADDR, 32'h0000_0001);
    check_mono_readback();
    send_frame(1'b0, 16'sd1000, 16'sh7FFF);
    send_frame(1'b0, -16'sd2000, 16'sh8000);
    send_frame(1'b0, 16'sd3000, 16'sh7FFF);
    drain_results();
    apb_write(UNUSED_ADDR, 32'hFFFF_FFFE);
    check_mono_readback();
    apb_write(MONO_ADDR, 32'hFFFF_FFFE);
    check_mono_readback();
    send_frame(1'b0, 16'sd10, -16'sd10);
    send_frame(1'b0, 16'sd20, -16'sd20);
  endtask

  // Random frames with occasional restarts so that peaks keep rebuilding.
  task automatic test_random_frames(input int unsigned count, input logic mono);
    drain_results();
    apb_write(MONO_ADDR, {{(DATA_BITS-1){1'b0}}, mono});
    for (int unsigned n = 0; n < count; n++) begin
      send_frame($urandom_range(99) < 4, pick_sample(), pick_sample());
    end
  endtask

  // The receiver holds off for a long stretch while frames keep coming.
  task automatic test_output_backpressure();
    steady = 1'b1;
    hold_request = 1'b1;
    for (int n = 0; n < 30; n++) begin
      send_frame(n == 0, pick_sample(), pick_sample());
    end
    steady = 1'b0;
  endtask

  // Result receiver: random stalls, or a long hold-off on request.
  initial begin : ready_driver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // Compare every result beat with the oldest expectation.
  always @(posedge clk) begin : peak_checker
    frame_result_t want;
    beat_moved = (s_tvalid && s_tready) || (m_tvalid && m_tready);
    if (!rst && m_tvalid && m_tready) begin
      if (pending_peaks.size() == 0) begin
        $display("%0t unexpected beat: true_peak %0d history_full %0b", $time,
                 m_tdata[PEAK_BITS-1:0], m_tuser);
        error_count++;
      end else begin
        want = pending_peaks.pop_front();
        if (m_tdata[PEAK_BITS-1:0] !== want.peak) begin
          $display("%0t true_peak: expected %0d, actual %0d", $time, want.peak,
                   m_tdata[PEAK_BITS-1:0]);
          error_count++;
        end
        if (m_tuser !== want.full) begin
          $display("%0t history_full: expected %0b, actual %0b", $time, want.full, m_tuser);
          error_count++;
        end
      end
    end
  end

  // Watchdog: too many cycles without any beat moving ends the run.
  initial begin : stall_watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      #1;
      quiet_cycles = beat_moved ? 0 : quiet_cycles + 1;
    end
    $display("stereo_true_peak_estimator_core_test: done, errors");
    $finish;
  end

  // Test sequence.
  initial begin
    rst <= 1'b1;
    s_tdata <= '0;
    s_tuser <= 1'b0;
    s_tvalid <= 1'b0;
    m_tready <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    error_count = 0;
    steady = 1'b0;
    hold_request = 1'b0;
    beat_moved = 1'b0;
    mono_shadow = 1'b0;
    frames_held = '0;
    peak_now = '0;
    for (int i = 0; i < NUM_TAPS; i++) begin
      left_taps[i] = '0;
      right_taps[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_fill_sequence();
    test_sample_extremes();
    test_restart();
    test_mono_mode();
    test_random_frames(350, 1'b0);
    test_random_frames(300, 1'b1);
    steady = 1'b1;
    test_random_frames(200, 1'b0);
    steady = 1'b0;
    test_random_frames(200, 1'b0);
    test_output_backpressure();
    drain_results();

    if (error_count == 0) begin
      $display("stereo_true_peak_estimator_core_test: done, clean");
    end else begin
      $display("stereo_true_peak_estimator_core_test: done, errors");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/stpe_pkg.sv
rtl/stpe_history.sv
rtl/stpe_interp.sv
rtl/stereo_true_peak_estimator_core.sv
verif/stereo_true_peak_estimator_core_test.sv
